// ----- rtl/ucjse_pkg.sv -----
// Shared types, constants and byte helpers for the UTF-8 checked JSON string escaper.
// No dependencies; every other file imports this package.
package ucjse_pkg;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int BUDGET_W = 10;
	localparam logic [BUDGET_W-1:0] BUDGET_RST = 10'd48;
	// Register index decoded from the word address bit
	localparam logic REG_BUDGET = 1'b0;

	// Queue geometry
	localparam int TOKQ_DEPTH = 8;
	localparam int TOKQ_AW = $clog2(TOKQ_DEPTH);
	localparam int STPQ_DEPTH = 4;
	localparam int STPQ_AW = $clog2(STPQ_DEPTH);

	// Character codes
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LOW_B = 8'h62;
	localparam logic [7:0] CH_LOW_F = 8'h66;
	localparam logic [7:0] CH_LOW_N = 8'h6E;
	localparam logic [7:0] CH_LOW_R = 8'h72;
	localparam logic [7:0] CH_LOW_T = 8'h74;
	localparam logic [7:0] CH_CAP_A = 8'h41;

	// Control bytes with a short escape, and the space that bounds the control range
	localparam logic [7:0] C_BS = 8'h08;
	localparam logic [7:0] C_FF = 8'h0C;
	localparam logic [7:0] C_LF = 8'h0A;
	localparam logic [7:0] C_CR = 8'h0D;
	localparam logic [7:0] C_HT = 8'h09;
	localparam logic [7:0] C_SPACE = 8'h20;

	// UTF-8 lead ranges and second-byte limits
	localparam logic [7:0] L2_LO = 8'hC2;
	localparam logic [7:0] L2_HI = 8'hDF;
	localparam logic [7:0] L3_LO = 8'hE0;
	localparam logic [7:0] L3_HI = 8'hEF;
	localparam logic [7:0] L4_LO = 8'hF0;
	localparam logic [7:0] L4_HI = 8'hF4;
	localparam logic [7:0] L3_SURR = 8'hED;
	localparam logic [7:0] S_A0 = 8'hA0;
	localparam logic [7:0] S_9F = 8'h9F;
	localparam logic [7:0] S_90 = 8'h90;
	localparam logic [7:0] S_8F = 8'h8F;

	typedef enum logic [2:0] {
		TK_RAW,   // one byte as is
		TK_ESC,   // backslash and one character
		TK_HEX,   // \u00XX
		TK_REPL,  // \uFFFD
		TK_UTF2,
		TK_UTF3,
		TK_UTF4
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [31:0] data;   // bytes of the token, first byte lowest
	} tok_t;

	typedef struct packed {
		logic       trunc;  // budget hit as it stands after the item
		logic       last;   // item ended the string
		logic [2:0] count;  // tokens queued for the item
	} step_t;

	// Front to queue
	typedef struct packed {
		logic  tok_push;
		tok_t  tok;
		logic  step_push;
		step_t step;
	} q_push_t;

	// Queue status seen by the front
	typedef struct packed {
		logic tok_full;
		logic step_full;
	} q_space_t;

	// Queue heads seen by the back
	typedef struct packed {
		logic  tok_valid;
		tok_t  tok;
		logic  step_valid;
		step_t step;
	} q_head_t;

	// Back to queue
	typedef struct packed {
		logic tok_pop;
		logic step_pop;
	} q_pop_t;

	function automatic logic [2:0] seq_len(input logic [7:0] lead);
		logic [2:0] n;
		n = 3'd0;
		case (lead) inside
			[L2_LO:L2_HI]: n = 3'd2;
			[L3_LO:L3_HI]: n = 3'd3;
			[L4_LO:L4_HI]: n = 3'd4;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] s);
		logic ok;
		ok = 1'b1;
		if (lead == L3_LO && s < S_A0) ok = 1'b0;
		if (lead == L3_SURR && s > S_9F) ok = 1'b0;
		if (lead == L4_LO && s < S_90) ok = 1'b0;
		if (lead == L4_HI && s > S_8F) ok = 1'b0;
		return ok;
	endfunction

	function automatic logic [2:0] tok_len(input tok_kind_t kind);
		logic [2:0] n;
		case (kind)
			TK_RAW:  n = 3'd1;
			TK_ESC:  n = 3'd2;
			TK_HEX:  n = 3'd6;
			TK_REPL: n = 3'd6;
			TK_UTF2: n = 3'd2;
			TK_UTF3: n = 3'd3;
			TK_UTF4: n = 3'd4;
			default: n = 3'd1;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10)
			c = CH_ZERO + {4'd0, d};
		else
			c = CH_CAP_A + {4'd0, d} - 8'd10;
		return c;
	endfunction

	// Byte idx of a token
	function automatic logic [7:0] tok_byte(input tok_t t, input logic [2:0] idx);
		logic [7:0] b;
		b = 8'h00;
		case (t.kind)
			TK_RAW: b = t.data[7:0];
			TK_ESC: b = (idx == 3'd0) ? CH_BSL : t.data[7:0];
			TK_HEX: begin
				case (idx)
					3'd0: b = CH_BSL;
					3'd1: b = CH_U;
					3'd2: b = CH_ZERO;
					3'd3: b = CH_ZERO;
					3'd4: b = hex_digit(t.data[7:4]);
					default: b = hex_digit(t.data[3:0]);
				endcase
			end
			TK_REPL: begin
				case (idx)
					3'd0: b = CH_BSL;
					3'd1: b = CH_U;
					3'd5: b = CH_D;
					default: b = CH_F;
				endcase
			end
			default: begin
				case (idx[1:0])
					2'd0: b = t.data[7:0];
					2'd1: b = t.data[15:8];
					2'd2: b = t.data[23:16];
					default: b = t.data[31:24];
				endcase
			end
		endcase
		return b;
	endfunction

endpackage

// ----- rtl/ucjse_front.sv -----
// Front part: accepts source bytes, runs the UTF-8 check and escape rules, applies the budget
// and queues whole tokens, plus a summary per item with tokens or a string end. Depends on ucjse_pkg.
module ucjse_front import ucjse_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	input  logic [BUDGET_W-1:0] budget,
	input  q_space_t            space,
	output q_push_t             push
);

	// Control state
	logic                busy_q;
	logic [1:0]          wn_q;
	logic                last_q;
	logic [1:0]          pc_q;
	logic [BUDGET_W-1:0] emitted_q;
	logic                bh_q;
	logic [2:0]          tokn_q;
	// Payload
	logic [2:0][7:0]     wq_q;
	logic [2:0][7:0]     pb_q;

	// Next values
	logic [2:0][7:0]     wq_n;
	logic [2:0][7:0]     pb_n;
	logic [1:0]          wn_n;
	logic [1:0]          pc_n;
	logic [BUDGET_W-1:0] emitted_n;
	logic                bh_n;
	logic [2:0]          tokn_n;

	logic        tok_req;
	tok_t        tok;
	logic [7:0]  x;
	logic [7:0]  lead;
	logic [2:0]  need;
	logic        cont_ok;
	logic [BUDGET_W:0] sum;
	logic        fits;
	logic        active;
	logic        finish;
	logic        fin_go;
	logic        tok_push;
	logic        accept;

	assign x    = wq_q[0];
	assign lead = pb_q[0];
	assign need = seq_len(lead);
	assign cont_ok = (x[7:6] == 2'b10) && ((pc_q != 2'd1) || second_ok(lead, x));
	assign active = busy_q && !space.tok_full && !space.step_full;

	// Process one byte of the work list, or flush a held lead at string end
	always_comb begin
		wq_n    = wq_q;
		wn_n    = wn_q;
		pb_n    = pb_q;
		pc_n    = pc_q;
		tok_req = 1'b0;
		tok     = '{kind: TK_REPL, data: 32'd0};
		if (wn_q != 2'd0) begin
			if (pc_q == 2'd0) begin
				wq_n = {8'h00, wq_q[2], wq_q[1]};
				wn_n = wn_q - 2'd1;
				if (!x[7]) begin
					tok_req = 1'b1;
					tok.data = {24'd0, x};
					case (x)
						CH_QUOTE: tok.kind = TK_ESC;
						CH_BSL:   tok.kind = TK_ESC;
						C_BS: begin
							tok.kind = TK_ESC;
							tok.data = {24'd0, CH_LOW_B};
						end
						C_FF: begin
							tok.kind = TK_ESC;
							tok.data = {24'd0, CH_LOW_F};
						end
						C_LF: begin
							tok.kind = TK_ESC;
							tok.data = {24'd0, CH_LOW_N};
						end
						C_CR: begin
							tok.kind = TK_ESC;
							tok.data = {24'd0, CH_LOW_R};
						end
						C_HT: begin
							tok.kind = TK_ESC;
							tok.data = {24'd0, CH_LOW_T};
						end
						default: tok.kind = (x < C_SPACE) ? TK_HEX : TK_RAW;
					endcase
				end else if (seq_len(x) != 3'd0) begin
					pb_n[0] = x;
					pc_n    = 2'd1;
				end else begin
					tok_req = 1'b1;
				end
			end else if (cont_ok) begin
				wq_n = {8'h00, wq_q[2], wq_q[1]};
				wn_n = wn_q - 2'd1;
				if ({1'b0, pc_q} + 3'd1 == need) begin
					// sequence complete: pass it through
					tok_req = 1'b1;
					pc_n    = 2'd0;
					case (need)
						3'd2: begin
							tok.kind = TK_UTF2;
							tok.data = {16'd0, x, pb_q[0]};
						end
						3'd3: begin
							tok.kind = TK_UTF3;
							tok.data = {8'd0, x, pb_q[1], pb_q[0]};
						end
						default: begin
							tok.kind = TK_UTF4;
							tok.data = {x, pb_q[2], pb_q[1], pb_q[0]};
						end
					endcase
				end else begin
					pc_n = pc_q + 2'd1;
					if (pc_q == 2'd1)
						pb_n[1] = x;
					else
						pb_n[2] = x;
				end
			end else begin
				// bad sequence: replace the lead, replay held bytes and this one
				tok_req = 1'b1;
				pc_n    = 2'd0;
				case (pc_q)
					2'd2: begin
						wq_n = {wq_q[1], wq_q[0], pb_q[1]};
						wn_n = wn_q + 2'd1;
					end
					2'd3: begin
						wq_n = {wq_q[0], pb_q[2], pb_q[1]};
						wn_n = wn_q + 2'd2;
					end
					default: begin
						wq_n = wq_q;
						wn_n = wn_q;
					end
				endcase
			end
		end else if (last_q && pc_q != 2'd0) begin
			// truncated at end: replace the lead, replay its continuations
			tok_req = 1'b1;
			wq_n    = {8'h00, pb_q[2], pb_q[1]};
			wn_n    = pc_q - 2'd1;
			pc_n    = 2'd0;
		end
	end

	// Budget check: a token goes out whole or not at all
	always_comb begin
		sum       = {1'b0, emitted_q} + {{(BUDGET_W-2){1'b0}}, tok_len(tok.kind)};
		fits      = sum <= {1'b0, budget};
		tok_push  = active && tok_req && !bh_q && fits;
		bh_n      = bh_q | (tok_req && !bh_q && !fits);
		emitted_n = tok_push ? sum[BUDGET_W-1:0] : emitted_q;
		tokn_n    = tokn_q + {2'd0, tok_push};
		finish    = (wn_n == 2'd0) && !(last_q && pc_n != 2'd0);
		fin_go    = active && finish;
	end

	assign in_ready = !busy_q || fin_go;
	assign accept   = in_valid && in_ready;

	always_comb begin
		push.tok_push   = tok_push;
		push.tok        = tok;
		push.step_push  = fin_go && (tokn_n != 3'd0 || last_q);
		push.step.trunc = bh_n;
		push.step.last  = last_q;
		push.step.count = tokn_n;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			wn_q      <= 2'd0;
			last_q    <= 1'b0;
			pc_q      <= 2'd0;
			emitted_q <= '0;
			bh_q      <= 1'b0;
			tokn_q    <= 3'd0;
		end else begin
			// Per-string state: clear it once the last byte is done
			if (active) begin
				if (finish && last_q) begin
					pc_q      <= 2'd0;
					emitted_q <= '0;
					bh_q      <= 1'b0;
				end else begin
					pc_q      <= pc_n;
					emitted_q <= emitted_n;
					bh_q      <= bh_n;
				end
			end
			// Per-item state: a new beat takes over from a finishing one
			if (accept) begin
				busy_q <= 1'b1;
				wn_q   <= 2'd1;
				last_q <= in_last;
				tokn_q <= 3'd0;
			end else if (active) begin
				wn_q   <= wn_n;
				tokn_q <= tokn_n;
				if (finish)
					busy_q <= 1'b0;
			end
		end
	end

	// Work list and held bytes
	always_ff @(posedge clk) begin
		if (active)
			pb_q <= pb_n;
		if (accept)
			wq_q <= {wq_q[2], wq_q[1], in_byte};
		else if (active)
			wq_q <= wq_n;
	end

	// A token is never queued once the budget has stopped output
	a_no_push_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		tok_push |-> !bh_q)
		else $error("token queued after budget hit");

	// The end of a string leaves no held lead and a fresh byte count
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go && last_q |=> pc_q == 2'd0 && emitted_q == '0 && !bh_q)
		else $error("string end did not clear state");

endmodule

// ----- rtl/ucjse_queue.sv -----
// Queue between front and back: a token ring and a ring of per-item summaries.
// Depends on ucjse_pkg.
module ucjse_queue import ucjse_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  q_push_t  push,
	output q_space_t space,
	input  q_pop_t   pop,
	output q_head_t  head
);

	tok_t  tok_mem_q [TOKQ_DEPTH];
	step_t stp_mem_q [STPQ_DEPTH];

	logic [TOKQ_AW-1:0] tok_wr_q;
	logic [TOKQ_AW-1:0] tok_rd_q;
	logic [TOKQ_AW:0]   tok_cnt_q;
	logic [STPQ_AW-1:0] stp_wr_q;
	logic [STPQ_AW-1:0] stp_rd_q;
	logic [STPQ_AW:0]   stp_cnt_q;

	assign space.tok_full  = tok_cnt_q == TOKQ_DEPTH[TOKQ_AW:0];
	assign space.step_full = stp_cnt_q == STPQ_DEPTH[STPQ_AW:0];

	assign head.tok_valid  = tok_cnt_q != '0;
	assign head.tok        = tok_mem_q[tok_rd_q];
	assign head.step_valid = stp_cnt_q != '0;
	assign head.step       = stp_mem_q[stp_rd_q];

	// Pointers and fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_wr_q  <= '0;
			tok_rd_q  <= '0;
			tok_cnt_q <= '0;
			stp_wr_q  <= '0;
			stp_rd_q  <= '0;
			stp_cnt_q <= '0;
		end else begin
			if (push.tok_push)
				tok_wr_q <= tok_wr_q + 1'b1;
			if (pop.tok_pop)
				tok_rd_q <= tok_rd_q + 1'b1;
			tok_cnt_q <= tok_cnt_q + {{TOKQ_AW{1'b0}}, push.tok_push}
				- {{TOKQ_AW{1'b0}}, pop.tok_pop};
			if (push.step_push)
				stp_wr_q <= stp_wr_q + 1'b1;
			if (pop.step_pop)
				stp_rd_q <= stp_rd_q + 1'b1;
			stp_cnt_q <= stp_cnt_q + {{STPQ_AW{1'b0}}, push.step_push}
				- {{STPQ_AW{1'b0}}, pop.step_pop};
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push.tok_push)
			tok_mem_q[tok_wr_q] <= push.tok;
		if (push.step_push)
			stp_mem_q[stp_wr_q] <= push.step;
	end

	a_tok_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.tok_push && !pop.tok_pop |-> !space.tok_full)
		else $error("token ring overflow");

	a_step_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop.step_pop |-> head.step_valid && (head.step.count == 3'd0 || pop.tok_pop))
		else $error("summary popped out of order with its tokens");

endmodule

// ----- rtl/ucjse_back.sv -----
// Back part: expands queued tokens into output bytes, with per-item flags from the summary
// ring, one beat per cycle while out_ready is high and an item waits. Depends on ucjse_pkg.
module ucjse_back import ucjse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  q_head_t    head,
	output q_pop_t     pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       run_last,
	output logic       string_done,
	output logic       was_truncated
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       has_byte_q;
	logic       run_last_q;
	logic       done_q;
	logic       trunc_q;
	logic [2:0] bi_q;
	logic [2:0] tk_q;

	logic       load;
	logic       tok_end;
	logic       step_end;
	logic       bare;
	logic [7:0] byte_n;

	// Start only on items whose tokens are all queued
	assign load     = head.step_valid && (!out_valid_q || out_ready);
	assign bare     = head.step.count == 3'd0;
	assign byte_n   = tok_byte(head.tok, bi_q);
	assign tok_end  = bi_q == tok_len(head.tok.kind) - 3'd1;
	assign step_end = bare || (tok_end && (tk_q + 3'd1 == head.step.count));

	always_comb begin
		pop.tok_pop  = load && !bare && tok_end;
		pop.step_pop = load && step_end;
	end

	// Byte and token position within the current item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			bi_q        <= 3'd0;
			tk_q        <= 3'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (step_end) begin
					bi_q <= 3'd0;
					tk_q <= 3'd0;
				end else if (tok_end) begin
					bi_q <= 3'd0;
					tk_q <= tk_q + 3'd1;
				end else begin
					bi_q <= bi_q + 3'd1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output beat register
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= bare ? 8'h00 : byte_n;
			has_byte_q <= !bare;
			run_last_q <= step_end;
			done_q     <= step_end && head.step.last;
			trunc_q    <= head.step.trunc;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign has_byte      = has_byte_q;
	assign run_last      = run_last_q;
	assign string_done   = done_q;
	assign was_truncated = trunc_q;

endmodule

// ----- rtl/utf8_checked_json_string_escaper.sv -----
// Top level of the UTF-8 checked JSON string escaper: stream ports, APB budget register,
// front, queue and back. Depends on ucjse_pkg, ucjse_front, ucjse_queue, ucjse_back.
//
// Source bytes enter on the s_ stream, one per beat, with s_tlast on the last byte of a
// string; encoded bytes leave on the m_ stream. Printable ASCII and valid UTF-8 pass as is,
// quote, backslash and controls are escaped, bad or truncated UTF-8 becomes \uFFFD, and
// output for a string stops once the next token would exceed output_budget (APB offset 0).
// Every source beat gives its results as one run closed by m_tlast; a beat with no output
// that ends a string gives a single beat with m_tuser low. Plain bytes flow at one per
// cycle once the pipe is full and while m_tready is high, each passing the front's work
// list, the queue and the back's output beat register. The front examines one byte
// at a time, so s_tready stays low while a beat replays held bytes of a failed sequence
// or flushes a lead still held at string end. The back sends one output byte per cycle
// while m_tready is high, up to 24 for an item; the eight-token queue and the four-item
// summary queue decide how far the front runs ahead before s_tready drops.
module utf8_checked_json_string_escaper import ucjse_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// Source stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,  // [7:0] in_byte
	input  logic               s_tlast,  // end_of_string
	// Encoded stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [15:0]        m_tdata,  // [7:0] out_byte, [8] string_done, [9] was_truncated
	output logic               m_tuser,  // has_byte
	output logic               m_tlast,  // run_last
	// Configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [BUDGET_W-1:0] budget_q;
	logic                cfg_wr;

	q_push_t  push;
	q_space_t space;
	q_pop_t   pop;
	q_head_t  head;

	logic [7:0] out_byte;
	logic       string_done;
	logic       was_truncated;

	// Budget register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BUDGET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BUDGET_RST;
		end else if (cfg_wr) begin
			budget_q <= pwdata[BUDGET_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_BUDGET) ? {{(PDATA_W-BUDGET_W){1'b0}}, budget_q} : '0;

	ucjse_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.budget   (budget_q),
		.space    (space),
		.push     (push)
	);

	ucjse_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.space  (space),
		.pop    (pop),
		.head   (head)
	);

	ucjse_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_byte      (out_byte),
		.has_byte      (m_tuser),
		.run_last      (m_tlast),
		.string_done   (string_done),
		.was_truncated (was_truncated)
	);

	assign m_tdata = {6'd0, was_truncated, string_done, out_byte};

endmodule
